// ----- sv/clc_pkg.sv -----
// shared types and constants of the charge limit controller
package clc_pkg;

    localparam int NUM_W = 26;    // 1000 * 16-bit capacity
    localparam int DEN_W = 17;    // full capacity plus one
    localparam int PCT_W = 10;
    localparam int LIM_W = 8;

    localparam logic [PCT_W-1:0] FULL_TENTHS  = 10'd1000;
    localparam logic [LIM_W-1:0] MIN_LIMIT    = 8'd20;
    localparam logic [LIM_W-1:0] OVERRIDE_BIT = 8'h80;
    localparam logic [LIM_W-1:0] FULL_OR_MASK = 8'h64;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_IDLE      = 2'd1;
    localparam logic [1:0] MODE_DISCHARGE = 2'd2;

    // classified item as it waits in the queue
    typedef struct packed {
        logic             ext_normal;
        logic             do_disable;
        logic             do_set;
        logic             set_err;
        logic             do_override;
        logic             do_get;
        logic [LIM_W-1:0] new_limit;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_item;

    // one result item
    typedef struct packed {
        logic             mode_valid;
        logic [1:0]       charge_mode;
        logic             discharge_on_ac;
        logic             status;
        logic             limit_reported;
        logic [LIM_W-1:0] reported_limit;
        logic [PCT_W-1:0] percent_tenths;
    } t_result;

endpackage

// ----- sv/clc_front.sv -----
// front end: decodes command bits and forms the dividend and divisor
module clc_front (
    input  logic                          i_req_type,
    input  logic [15:0]                   i_remaining_cap,
    input  logic [15:0]                   i_full_cap,
    input  logic                          i_ext_mode_normal,
    input  logic                          i_cmd_disable,
    input  logic                          i_cmd_set,
    input  logic                          i_cmd_override,
    input  logic                          i_cmd_get,
    input  logic [clc_pkg::LIM_W-1:0]     i_new_limit,
    output clc_pkg::t_item                o_item
);

    logic set_low;

    // command bits only count on a host command
    assign set_low = (i_new_limit < clc_pkg::MIN_LIMIT);

    always_comb begin
        o_item             = '0;
        o_item.ext_normal  = i_ext_mode_normal;
        o_item.do_disable  = i_req_type & i_cmd_disable;
        o_item.set_err     = i_req_type & i_cmd_set & set_low;
        o_item.do_set      = i_req_type & i_cmd_set & ~set_low;
        o_item.do_override = i_req_type & i_cmd_override;
        o_item.do_get      = i_req_type & i_cmd_get;
        o_item.new_limit   = i_new_limit;
        // dividend 1000 * remaining, divisor full + 1
        o_item.num = clc_pkg::NUM_W'(i_remaining_cap) *
                     clc_pkg::NUM_W'(clc_pkg::FULL_TENTHS);
        o_item.den = clc_pkg::DEN_W'(i_full_cap) + clc_pkg::DEN_W'(1);
    end

endmodule

// ----- sv/clc_queue.sv -----
// short queue between front end and back end
module clc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  clc_pkg::t_item i_wr_item,
    input  logic           i_rd,
    output clc_pkg::t_item o_rd_item,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    clc_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en, rd_en;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr & ~o_full;
    assign rd_en     = i_rd & ~o_empty;
    assign o_rd_item = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/clc_back.sv -----
// back end: serial divider, limit state, mode decision and result register
module clc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [clc_pkg::LIM_W-1:0]  i_cfg_data,
    input  logic                       i_q_empty,
    input  clc_pkg::t_item             i_q_item,
    output logic                       o_q_rd,
    input  logic                       i_pop,
    output logic                       o_res_valid,
    output clc_pkg::t_result           o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam int CNT_W = $clog2(clc_pkg::NUM_W);

    logic [1:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt;
    clc_pkg::t_item                r_item;
    logic [clc_pkg::DEN_W-1:0]     r_rem;
    logic [clc_pkg::NUM_W-1:0]     r_quo;
    logic [clc_pkg::LIM_W-1:0]     r_backup;
    logic [clc_pkg::LIM_W-1:0]     r_limit, n_limit;
    logic                          r_loaded, n_loaded;
    logic [clc_pkg::LIM_W-1:0]     r_saved, n_saved;
    logic                          r_saved_wr, n_saved_wr;
    logic                          r_ilc, n_ilc;
    logic [clc_pkg::PCT_W-1:0]     r_last, n_last;
    clc_pkg::t_result              r_out, n_out;
    logic                          r_out_valid;

    logic [clc_pkg::DEN_W:0]       trial, diff;
    logic                          commit;
    logic [clc_pkg::PCT_W-1:0]     pct;
    logic [11:0]                   lim10;

    assign o_q_rd      = (r_state == ST_IDLE) & ~i_q_empty;
    assign commit      = (r_state == ST_EXEC) & (~r_out_valid | i_pop);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // restoring divider step
    assign trial = {r_rem, r_quo[clc_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_item.den};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_item.set_err ? ST_EXEC : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(clc_pkg::NUM_W - 1)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command handling and mode decision, in command order
    always_comb begin
        n_limit    = r_limit;
        n_loaded   = r_loaded;
        n_saved    = r_saved;
        n_saved_wr = r_saved_wr;
        n_ilc      = r_ilc;
        n_last     = r_last;
        n_out      = '0;
        pct        = r_last;
        lim10      = '0;
        if (r_item.do_disable) begin
            n_limit    = '0;
            n_loaded   = 1'b1;
            n_saved    = '0;
            n_saved_wr = 1'b1;
        end
        if (r_item.set_err) begin
            n_out.status = 1'b1;
        end else begin
            if (r_item.do_set) begin
                n_limit    = r_item.new_limit;
                n_loaded   = 1'b1;
                n_saved    = r_item.new_limit;
                n_saved_wr = 1'b1;
            end
            if (r_item.do_override) begin
                if (!n_loaded) begin
                    n_limit = n_saved_wr ? n_saved : r_backup;
                end
                n_loaded = 1'b1;
                n_limit  = n_limit | clc_pkg::OVERRIDE_BIT;
            end
            if (r_item.do_get) begin
                n_limit              = n_saved_wr ? n_saved : r_backup;
                n_loaded             = 1'b1;
                n_out.limit_reported = 1'b1;
                n_out.reported_limit = n_limit;
            end
            // out-of-range level keeps the last good one
            if (r_quo <= clc_pkg::NUM_W'(clc_pkg::FULL_TENTHS)) begin
                pct    = r_quo[clc_pkg::PCT_W-1:0];
                n_last = pct;
            end
            n_out.percent_tenths = pct;
            if (r_ilc || r_item.ext_normal) begin
                if (!n_loaded) begin
                    n_limit = n_saved_wr ? n_saved : r_backup;
                end
                n_loaded         = 1'b1;
                lim10            = 12'(n_limit) * 12'd10;
                n_out.mode_valid = 1'b1;
                if ((n_limit & clc_pkg::OVERRIDE_BIT) != '0) begin
                    n_out.charge_mode = clc_pkg::MODE_NORMAL;
                    if (pct == clc_pkg::FULL_TENTHS) begin
                        n_limit = n_limit | clc_pkg::FULL_OR_MASK;
                    end
                end else if (n_limit < clc_pkg::MIN_LIMIT) begin
                    n_out.charge_mode = clc_pkg::MODE_NORMAL;
                end else if (12'(pct) > lim10) begin
                    n_out.charge_mode     = clc_pkg::MODE_DISCHARGE;
                    n_out.discharge_on_ac = 1'b1;
                    n_ilc                 = 1'b1;
                end else if (12'(pct) == lim10) begin
                    n_out.charge_mode = clc_pkg::MODE_IDLE;
                    n_ilc             = 1'b1;
                end else begin
                    n_out.charge_mode = clc_pkg::MODE_NORMAL;
                    n_ilc             = 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_item <= i_q_item;
            r_rem  <= '0;
            r_quo  <= i_q_item.num;
            r_cnt  <= '0;
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!diff[clc_pkg::DEN_W]) begin
                r_rem <= diff[clc_pkg::DEN_W-1:0];
                r_quo <= {r_quo[clc_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[clc_pkg::DEN_W-1:0];
                r_quo <= {r_quo[clc_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    // control and limit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_backup    <= '0;
            r_limit     <= '0;
            r_loaded    <= 1'b0;
            r_saved     <= '0;
            r_saved_wr  <= 1'b0;
            r_ilc       <= 1'b0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_backup <= i_cfg_data;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_limit     <= n_limit;
                r_loaded    <= n_loaded;
                r_saved     <= n_saved;
                r_saved_wr  <= n_saved_wr;
                r_ilc       <= n_ilc;
                r_last      <= n_last;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/battery_charge_limit_controller_top.sv -----
// top level of the battery charge limit controller
//
// channel   direction  handshake             payload
// input     in         push / full           i_req_type .. i_new_limit
// result    out        empty / pop           o_mode_valid .. o_percent_tenths
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_data (power-up saved limit)
//
// each back-end item is loaded, runs through the radix-2 restoring divider, one
// iteration per bit of the 26-bit quotient, and is decided and written to the result
// register once that is free; a host set with a limit below 20 skips the divider
// the front end keeps filling the queue while the back end divides or waits on pop
// reset is synchronous, active low, and clears queue, sequencer and limit state
module battery_charge_limit_controller_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [15:0] i_remaining_cap,
    input  logic [15:0] i_full_cap,
    input  logic        i_ext_mode_normal,
    input  logic        i_cmd_disable,
    input  logic        i_cmd_set,
    input  logic        i_cmd_override,
    input  logic        i_cmd_get,
    input  logic [7:0]  i_new_limit,
    output logic        empty,
    input  logic        pop,
    output logic        o_mode_valid,
    output logic [1:0]  o_charge_mode,
    output logic        o_discharge_on_ac,
    output logic        o_status,
    output logic        o_limit_reported,
    output logic [7:0]  o_reported_limit,
    output logic [9:0]  o_percent_tenths
);

    clc_pkg::t_item   front_item, q_item;
    clc_pkg::t_result res;
    logic             q_empty, q_rd, res_valid;

    assign o_cfg_ready = 1'b1;

    // classify items
    clc_front u_front (
        .i_req_type        (i_req_type),
        .i_remaining_cap   (i_remaining_cap),
        .i_full_cap        (i_full_cap),
        .i_ext_mode_normal (i_ext_mode_normal),
        .i_cmd_disable     (i_cmd_disable),
        .i_cmd_set         (i_cmd_set),
        .i_cmd_override    (i_cmd_override),
        .i_cmd_get         (i_cmd_get),
        .i_new_limit       (i_new_limit),
        .o_item            (front_item)
    );

    // decoupling queue
    clc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (front_item),
        .i_rd      (q_rd),
        .o_rd_item (q_item),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    // divide, decide, hold result
    clc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_item    (q_item),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign empty             = ~res_valid;
    assign o_mode_valid      = res.mode_valid;
    assign o_charge_mode     = res.charge_mode;
    assign o_discharge_on_ac = res.discharge_on_ac;
    assign o_status          = res.status;
    assign o_limit_reported  = res.limit_reported;
    assign o_reported_limit  = res.reported_limit;
    assign o_percent_tenths  = res.percent_tenths;

endmodule

// ----- bench/clc_checker.sv -----
// checker for the charge limit controller: predicts each result item and compares it
module clc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_push,
    input  logic       i_full,
    input  logic       i_req_type,
    input  logic [15:0] i_remaining_cap,
    input  logic [15:0] i_full_cap,
    input  logic       i_ext_mode_normal,
    input  logic       i_cmd_disable,
    input  logic       i_cmd_set,
    input  logic       i_cmd_override,
    input  logic       i_cmd_get,
    input  logic [7:0] i_new_limit,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic       i_mode_valid,
    input  logic [1:0] i_charge_mode,
    input  logic       i_discharge_on_ac,
    input  logic       i_status,
    input  logic       i_limit_reported,
    input  logic [7:0] i_reported_limit,
    input  logic [9:0] i_percent_tenths,
    output int         o_fail_count,
    output int         o_pending
);

    // mirror of the controller state
    logic [clc_pkg::LIM_W-1:0] powerup_limit;
    logic [clc_pkg::LIM_W-1:0] limit_level;
    logic                      limit_loaded;
    logic [clc_pkg::LIM_W-1:0] saved_limit;
    logic                      saved_written;
    logic                      in_limit_control;
    logic [clc_pkg::PCT_W-1:0] last_level;

    clc_pkg::t_result awaited_results[$];
    clc_pkg::t_result want;
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    // battery-backed copy, or the power-up value until first written
    function automatic logic [clc_pkg::LIM_W-1:0] saved_copy();
        return saved_written ? saved_limit : powerup_limit;
    endfunction

    function automatic void load_limit_once();
        if (!limit_loaded) begin
            limit_level  = saved_copy();
            limit_loaded = 1'b1;
        end
    endfunction

    // expected result of one item, updating the mirrored state
    function automatic clc_pkg::t_result decide_charge_result(
        input logic        req_type,
        input logic [15:0] rem_cap,
        input logic [15:0] full_c,
        input logic        ext_normal,
        input logic        cmd_dis,
        input logic        cmd_st,
        input logic        cmd_ovr,
        input logic        cmd_gt,
        input logic [7:0]  req_limit
    );
        clc_pkg::t_result          res;
        int unsigned               quot;
        int unsigned               lim10;
        logic [clc_pkg::PCT_W-1:0] level;
        res = '0;
        // host commands in fixed order
        if (req_type) begin
            if (cmd_dis) begin
                limit_level   = '0;
                limit_loaded  = 1'b1;
                saved_limit   = '0;
                saved_written = 1'b1;
            end
            if (cmd_st) begin
                if (req_limit < clc_pkg::MIN_LIMIT) begin
                    res.status = 1'b1;
                    return res;
                end
                limit_level   = req_limit;
                limit_loaded  = 1'b1;
                saved_limit   = req_limit;
                saved_written = 1'b1;
            end
            if (cmd_ovr) begin
                load_limit_once();
                limit_level = limit_level | clc_pkg::OVERRIDE_BIT;
            end
            if (cmd_gt) begin
                limit_level        = saved_copy();
                limit_loaded       = 1'b1;
                res.limit_reported = 1'b1;
                res.reported_limit = limit_level;
            end
        end
        // charge level, keeping the last valid one when out of range
        quot = (32'd1000 * {16'd0, rem_cap}) / ({16'd0, full_c} + 32'd1);
        if (quot <= clc_pkg::FULL_TENTHS) begin
            level      = quot[clc_pkg::PCT_W-1:0];
            last_level = level;
        end else begin
            level = last_level;
        end
        res.percent_tenths = level;
        // mode decision
        if (in_limit_control || ext_normal) begin
            load_limit_once();
            lim10          = limit_level * 10;
            res.mode_valid = 1'b1;
            if ((limit_level & clc_pkg::OVERRIDE_BIT) != '0) begin
                res.charge_mode = clc_pkg::MODE_NORMAL;
                if (level == clc_pkg::FULL_TENTHS)
                    limit_level = limit_level | clc_pkg::FULL_OR_MASK;
            end else if (limit_level < clc_pkg::MIN_LIMIT) begin
                res.charge_mode = clc_pkg::MODE_NORMAL;
            end else if (level > lim10) begin
                res.charge_mode  = clc_pkg::MODE_DISCHARGE;
                in_limit_control = 1'b1;
            end else if (level == lim10) begin
                res.charge_mode  = clc_pkg::MODE_IDLE;
                in_limit_control = 1'b1;
            end else begin
                res.charge_mode  = clc_pkg::MODE_NORMAL;
                in_limit_control = 1'b0;
            end
            res.discharge_on_ac = (res.charge_mode == clc_pkg::MODE_DISCHARGE);
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // watch the channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            powerup_limit    = '0;
            limit_level      = '0;
            limit_loaded     = 1'b0;
            saved_limit      = '0;
            saved_written    = 1'b0;
            in_limit_control = 1'b0;
            last_level       = '0;
            awaited_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result item expected none, actual percent %0d",
                             $time, i_percent_tenths);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("mode_valid", 32'(want.mode_valid), 32'(i_mode_valid));
                    check_field("charge_mode", 32'(want.charge_mode), 32'(i_charge_mode));
                    check_field("discharge_on_ac", 32'(want.discharge_on_ac),
                                32'(i_discharge_on_ac));
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("limit_reported", 32'(want.limit_reported),
                                32'(i_limit_reported));
                    check_field("reported_limit", 32'(want.reported_limit),
                                32'(i_reported_limit));
                    check_field("percent_tenths", 32'(want.percent_tenths),
                                32'(i_percent_tenths));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                powerup_limit = i_cfg_data;
            if (i_push && !i_full)
                awaited_results.push_back(decide_charge_result(
                    i_req_type, i_remaining_cap, i_full_cap, i_ext_mode_normal,
                    i_cmd_disable, i_cmd_set, i_cmd_override, i_cmd_get, i_new_limit));
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ----- bench/testbench.sv -----
// top of the charge limit controller bench: clock, reset, stimulus and verdict
module testbench;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic        i_req_type = 1'b0;
    logic [15:0] i_remaining_cap = '0;
    logic [15:0] i_full_cap = '0;
    logic        i_ext_mode_normal = 1'b0;
    logic        i_cmd_disable = 1'b0;
    logic        i_cmd_set = 1'b0;
    logic        i_cmd_override = 1'b0;
    logic        i_cmd_get = 1'b0;
    logic [7:0]  i_new_limit = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_mode_valid;
    logic [1:0]  o_charge_mode;
    logic        o_discharge_on_ac;
    logic        o_status;
    logic        o_limit_reported;
    logic [7:0]  o_reported_limit;
    logic [9:0]  o_percent_tenths;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 18;
    int   recv_idle_pct = 18;
    logic hold_off_req = 1'b0;
    int   cycles = 0;

    always #10 i_clk = ~i_clk;

    battery_charge_limit_controller_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_remaining_cap  (i_remaining_cap),
        .i_full_cap       (i_full_cap),
        .i_ext_mode_normal(i_ext_mode_normal),
        .i_cmd_disable    (i_cmd_disable),
        .i_cmd_set        (i_cmd_set),
        .i_cmd_override   (i_cmd_override),
        .i_cmd_get        (i_cmd_get),
        .i_new_limit      (i_new_limit),
        .empty            (empty),
        .pop              (pop),
        .o_mode_valid     (o_mode_valid),
        .o_charge_mode    (o_charge_mode),
        .o_discharge_on_ac(o_discharge_on_ac),
        .o_status         (o_status),
        .o_limit_reported (o_limit_reported),
        .o_reported_limit (o_reported_limit),
        .o_percent_tenths (o_percent_tenths)
    );

    clc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_push           (push),
        .i_full           (full),
        .i_req_type       (i_req_type),
        .i_remaining_cap  (i_remaining_cap),
        .i_full_cap       (i_full_cap),
        .i_ext_mode_normal(i_ext_mode_normal),
        .i_cmd_disable    (i_cmd_disable),
        .i_cmd_set        (i_cmd_set),
        .i_cmd_override   (i_cmd_override),
        .i_cmd_get        (i_cmd_get),
        .i_new_limit      (i_new_limit),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_mode_valid     (o_mode_valid),
        .i_charge_mode    (o_charge_mode),
        .i_discharge_on_ac(o_discharge_on_ac),
        .i_status         (o_status),
        .i_limit_reported (o_limit_reported),
        .i_reported_limit (o_reported_limit),
        .i_percent_tenths (o_percent_tenths),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // watchdog on the cycle count
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // result side: random pops, with one long hold-off on request
    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one item after a random gap and wait until it is taken
    task automatic offer_request(input logic rt, input logic [15:0] rem_cap,
                                 input logic [15:0] full_c, input logic ext_normal,
                                 input logic cmd_dis, input logic cmd_st,
                                 input logic cmd_ovr, input logic cmd_gt,
                                 input logic [7:0] req_limit);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_req_type        <= rt;
        i_remaining_cap   <= rem_cap;
        i_full_cap        <= full_c;
        i_ext_mode_normal <= ext_normal;
        i_cmd_disable     <= cmd_dis;
        i_cmd_set         <= cmd_st;
        i_cmd_override    <= cmd_ovr;
        i_cmd_get         <= cmd_gt;
        i_new_limit       <= req_limit;
        push              <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    // random item, weighted toward limit thresholds and level ties
    task automatic offer_random_request();
        logic        rt;
        logic        ext_normal;
        logic [7:0]  req_limit;
        logic [15:0] rem_cap;
        logic [15:0] full_c;
        rt         = 1'($urandom_range(1));
        ext_normal = ($urandom_range(3) != 0);
        case ($urandom_range(9))
            0, 1, 2:    req_limit = 8'(18 + $urandom_range(4));
            3, 4, 5, 6: req_limit = 8'(20 + $urandom_range(80));
            default:    req_limit = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                full_c  = 16'd999;
                rem_cap = 16'($urandom_range(100, 20) * 10 + $urandom_range(2) - 1);
            end
            4: begin
                full_c  = 16'd999;
                rem_cap = 16'($urandom_range(1005, 995));
            end
            5: begin
                full_c  = 16'($urandom);
                rem_cap = 16'(full_c + $urandom_range(1));
            end
            6: begin
                full_c  = 16'($urandom_range(3));
                rem_cap = 16'($urandom);
            end
            default: begin
                full_c  = 16'($urandom);
                rem_cap = 16'($urandom);
            end
        endcase
        offer_request(rt, rem_cap, full_c, ext_normal, ($urandom_range(7) == 0),
                      ($urandom_range(2) == 0), ($urandom_range(4) == 0),
                      ($urandom_range(3) == 0), req_limit);
    endtask

    // stop offering and wait until every result item is back
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_powerup_limit(input logic [7:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        int phase;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-up value zero: ignored command bits, over-range level, first load
        write_powerup_limit(8'h00);
        offer_request(1'b0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0);
        offer_request(1'b0, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
        drain_results();

        // power-up value all ones: override bit set, full charge
        write_powerup_limit(8'hFF);
        offer_request(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0);
        offer_request(1'b0, 16'd1000, 16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        drain_results();

        // limit 90: idle, discharge, leaving control, mode set elsewhere
        write_powerup_limit(8'd90);
        offer_request(1'b1, 16'd900, 16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0);
        offer_request(1'b0, 16'd950, 16'd999, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        offer_request(1'b0, 16'd500, 16'd999, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        offer_request(1'b0, 16'd950, 16'd999, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        drain_results();

        // limit just below the minimum, then the command paths
        write_powerup_limit(8'd19);
        offer_request(1'b1, 16'd100, 16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0);
        offer_request(1'b1, 16'd300, 16'd999, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd19);
        offer_request(1'b1, 16'd300, 16'd999, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0);
        offer_request(1'b1, 16'd200, 16'd999, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd20);
        offer_request(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd255);
        offer_request(1'b1, 16'd1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
        offer_request(1'b1, 16'd1000, 16'd999, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd50);
        offer_request(1'b1, 16'd1000, 16'd999, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0);
        offer_request(1'b1, 16'd500, 16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0);
        offer_request(1'b0, 16'hFFFF, 16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        offer_request(1'b1, 16'd300, 16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
        offer_request(1'b1, 16'd999, 16'd999, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd100);
        drain_results();

        // random phases, one without idling, one with a long result hold-off
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = (phase == 2) ? 0 : 18;
            recv_idle_pct = (phase == 2) ? 0 : 18;
            case (phase)
                0:       write_powerup_limit(8'hFF);
                1:       write_powerup_limit(8'h00);
                default: write_powerup_limit(8'($urandom_range(255)));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == 30)
                    hold_off_req = 1'b1;
                offer_random_request();
            end
            drain_results();
        end

        repeat (64) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/clc_pkg.sv
sv/clc_front.sv
sv/clc_queue.sv
sv/clc_back.sv
sv/battery_charge_limit_controller_top.sv
bench/clc_checker.sv
bench/testbench.sv
